/* hdl/silence_framed_receive_deframer_defines.svh */
// ----------------------------------------------------------------------------
// Silence-framed receive deframer: assertion macros
// Concurrent checks on clk with synchronous reset rst_n; NO_ASSERTIONS
// compiles them out.
// ----------------------------------------------------------------------------
`ifndef SILENCE_FRAMED_RECEIVE_DEFRAMER_DEFINES_SVH
`define SILENCE_FRAMED_RECEIVE_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SFRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SFRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFRD_ASSERT_IMPL(lbl, ante, cons, msg)
`define SFRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/sfrd_pkg.sv */
// ----------------------------------------------------------------------------
// sfrd_pkg
// Types, codes and constants shared by the deframer front, queue and back.
// ----------------------------------------------------------------------------
package sfrd_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int MIN_FRAME_DEF    = 5;
  localparam int Q_DEPTH          = 2;

  localparam logic [7:0]  START_BYTE        = 8'h00;
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'd1;
  localparam logic [15:0] SILENCE_RESET     = 16'd35;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_SLAVE_ADDR = 1'b0;
  localparam logic REG_SILENCE    = 1'b1;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_IDLE  = 2'd1,
    MODE_RCV   = 2'd2,
    MODE_ERROR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_LINE_READY    = 2'd0,
    EV_PAYLOAD       = 2'd1,
    EV_BAD_FRAME     = 2'd2,
    EV_OTHER_STATION = 2'd3
  } event_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SEND = 1'b1
  } back_state_t;

  // one queued outcome of an expiry: a status code, or a payload run of plen
  typedef struct packed {
    event_t     ev;
    logic [5:0] plen;
  } job_t;

  typedef struct packed {
    logic run_active;
    logic run_done;
  } back_status_t;

  // high nibble * 10 + low nibble, wrapping at 8 bits
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    bcd_value = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
  endfunction

endpackage

/* hdl/sfrd_queue.sv */
// ----------------------------------------------------------------------------
// sfrd_queue
// Short job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module sfrd_queue
  import sfrd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic full,
  output logic empty
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  job_t           slot_r [Q_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCW'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(Q_DEPTH - 1)) ? '0 : wp_r + QAW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == QAW'(Q_DEPTH - 1)) ? '0 : rp_r + QAW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCW'(1);
      2'b01:   cnt_nxt = cnt_r - QCW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

/* hdl/sfrd_front.sv */
// ----------------------------------------------------------------------------
// sfrd_front
// Accepts bytes and ticks, runs the receive mode and silence timer, writes
// the frame memory and classifies each expiry out of init or receive into a queued job.
// ----------------------------------------------------------------------------
module sfrd_front
  import sfrd_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MIN_FRAME    = MIN_FRAME_DEF,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int FW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_cmd,
  input  logic [7:0]    in_rx_byte,
  input  logic [7:0]    slave_address,
  input  logic [15:0]   silence_ticks,
  input  logic          q_full,
  output logic          q_push,
  output job_t          q_job,
  input  back_status_t  bk_status,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  mode_t         mode_r, mode_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0]   cnt_r, cnt_nxt;
  logic          timer_r, timer_nxt;
  logic          run_out_r, run_out_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    byte0_r, byte0_nxt;
  logic [7:0]    byte1_r, byte1_nxt;
  logic [7:0]    p1_r, p1_nxt;
  logic [7:0]    p2_r, p2_nxt;

  logic          accept;
  logic [15:0]   cnt_inc;
  logic [15:0]   limit;
  logic          len_ok, start_ok, sum_ok, addr_ok;
  logic [5:0]    plen;

  assign in_stall = q_full | run_out_r;
  assign accept   = in_valid & ~in_stall;
  assign wr_data  = in_rx_byte;

  assign cnt_inc  = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;
  assign limit    = (silence_ticks == 16'd0) ? 16'd1 : silence_ticks;

  // sum_r covers address through trailer; take the two trailer bytes back out
  assign len_ok   = (fill_r >= FW'(MIN_FRAME));
  assign start_ok = (byte0_r == START_BYTE);
  assign sum_ok   = ((sum_r - {8'h00, p1_r} - {8'h00, p2_r}) == {p1_r, p2_r});
  assign addr_ok  = (bcd_value(byte1_r) == slave_address);
  assign plen     = 6'(fill_r - FW'(4));

  always_comb begin
    mode_nxt    = mode_r;
    fill_nxt    = fill_r;
    cnt_nxt     = cnt_r;
    timer_nxt   = timer_r;
    run_out_nxt = run_out_r & ~bk_status.run_done;
    sum_nxt     = sum_r;
    byte0_nxt   = byte0_r;
    byte1_nxt   = byte1_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    wr_en       = 1'b0;
    wr_addr     = fill_r[AW-1:0];
    q_push      = 1'b0;
    q_job       = '{ev: EV_BAD_FRAME, plen: 6'd0};

    if (accept) begin
      if (in_cmd == CMD_BYTE) begin
        cnt_nxt   = 16'd0;
        timer_nxt = 1'b1;
        case (mode_r)
          MODE_IDLE: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            byte0_nxt = in_rx_byte;
            fill_nxt  = FW'(1);
            sum_nxt   = 16'd0;
            mode_nxt  = MODE_RCV;
          end
          MODE_RCV: begin
            if (fill_r < FW'(BUFFER_BYTES)) begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + FW'(1);
              sum_nxt  = sum_r + {8'h00, in_rx_byte};
              p1_nxt   = in_rx_byte;
              p2_nxt   = p1_r;
              if (fill_r == FW'(1)) begin
                byte1_nxt = in_rx_byte;
              end
            end else begin
              mode_nxt = MODE_ERROR;
            end
          end
          default: ;
        endcase
      end else if (timer_r) begin
        if (cnt_inc >= limit) begin
          mode_nxt  = MODE_IDLE;
          timer_nxt = 1'b0;
          cnt_nxt   = 16'd0;
          case (mode_r)
            MODE_INIT: begin
              q_push   = 1'b1;
              q_job.ev = EV_LINE_READY;
            end
            MODE_RCV: begin
              q_push = 1'b1;
              if (!len_ok || !start_ok || !sum_ok) begin
                q_job.ev = EV_BAD_FRAME;
              end else if (!addr_ok) begin
                q_job.ev = EV_OTHER_STATION;
              end else begin
                q_job.ev    = EV_PAYLOAD;
                q_job.plen  = plen;
                run_out_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_INIT;
      fill_r    <= '0;
      cnt_r     <= 16'd0;
      timer_r   <= 1'b1;
      run_out_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      timer_r   <= timer_nxt;
      run_out_r <= run_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    byte0_r <= byte0_nxt;
    byte1_r <= byte1_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
  end

endmodule

/* hdl/sfrd_back.sv */
// ----------------------------------------------------------------------------
// sfrd_back
// Holds the frame memory, takes jobs from the queue and drives the result
// channel through an output register.
// ----------------------------------------------------------------------------
module sfrd_back
  import sfrd_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  job_t          q_job,
  output logic          q_pop,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output back_status_t  bk_status,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_event_res,
  output logic [7:0]    out_payload_byte,
  output logic          out_last,
  output logic [5:0]    out_payload_length
);

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  back_state_t   state_r, state_nxt;
  logic [5:0]    idx_r, idx_nxt;
  logic [5:0]    plen_r, plen_nxt;

  logic          out_valid_r, out_valid_nxt;
  event_t        ev_r, ev_nxt;
  logic [7:0]    pb_r, pb_nxt;
  logic          last_r, last_nxt;
  logic [5:0]    len_r, len_nxt;

  logic          out_free;
  logic          run_last;

  assign out_free = ~out_valid_r | ~out_stall;
  assign run_last = (idx_r == plen_r - 6'd1);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    plen_nxt      = plen_r;
    out_valid_nxt = out_valid_r & out_stall;
    ev_nxt        = ev_r;
    pb_nxt        = pb_r;
    last_nxt      = last_r;
    len_nxt       = len_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = AW'(7'(idx_r) + 7'd3);
    bk_status     = '{run_active: (state_r == BK_SEND), run_done: 1'b0};

    case (state_r)
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_job.ev == EV_PAYLOAD) begin
            // payload starts after start and address bytes
            rd_en     = 1'b1;
            rd_addr   = AW'(2);
            idx_nxt   = 6'd0;
            plen_nxt  = q_job.plen;
            state_nxt = BK_SEND;
          end else begin
            out_valid_nxt = 1'b1;
            ev_nxt        = q_job.ev;
            pb_nxt        = 8'h00;
            last_nxt      = 1'b1;
            len_nxt       = 6'd0;
          end
        end
      end
      BK_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ev_nxt        = EV_PAYLOAD;
          pb_nxt        = rdata_r;
          last_nxt      = run_last;
          len_nxt       = plen_r;
          if (run_last) begin
            state_nxt          = BK_IDLE;
            bk_status.run_done = 1'b1;
          end else begin
            // fetch the next byte while this one sits in the output register
            idx_nxt = idx_r + 6'd1;
            rd_en   = 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    plen_r <= plen_nxt;
    ev_r   <= ev_nxt;
    pb_r   <= pb_nxt;
    last_r <= last_nxt;
    len_r  <= len_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = ev_r;
  assign out_payload_byte   = pb_r;
  assign out_last           = last_r;
  assign out_payload_length = len_r;

endmodule

/* hdl/silence_framed_receive_deframer.sv */
// ----------------------------------------------------------------------------
// silence_framed_receive_deframer
// Receive deframer for silence-delimited frames with an additive checksum.
// ----------------------------------------------------------------------------
// Every input beat (a line byte or a timer tick) is taken while in_stall is
// low. A tick that ends the silence after init or a received frame queues
// one job in a two-entry queue; a status result is popped from the queue
// into the output register. A good frame drains from the frame memory's
// registered read port one payload byte per cycle while the result side
// takes them, each byte passing the read register and then the output
// register. The input side stalls from the expiry of a good frame until
// its last payload beat has been loaded, and while the job queue is full.
// Configuration registers: slave_address at byte 0, silence_ticks at byte 4.
// ----------------------------------------------------------------------------
`include "silence_framed_receive_deframer_defines.svh"

module silence_framed_receive_deframer
  import sfrd_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MIN_FRAME    = MIN_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  output logic [5:0]  out_payload_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [7:0]    slave_address_r;
  logic [15:0]   silence_ticks_r;
  logic          cfg_write;

  logic          q_push, q_pop, q_full, q_empty;
  job_t          q_push_job, q_head_job;
  back_status_t  bk_status;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= SLAVE_ADDR_RESET;
      silence_ticks_r <= SILENCE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SLAVE_ADDR: slave_address_r <= pwdata[7:0];
        REG_SILENCE:    silence_ticks_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLAVE_ADDR: prdata = {24'h000000, slave_address_r};
      REG_SILENCE:    prdata = {16'h0000, silence_ticks_r};
      default:        prdata = 32'h00000000;
    endcase
  end

  sfrd_front #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MIN_FRAME    (MIN_FRAME)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_rx_byte    (in_rx_byte),
    .slave_address (slave_address_r),
    .silence_ticks (silence_ticks_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_push_job),
    .bk_status     (bk_status),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  sfrd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfrd_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_job              (q_head_job),
    .q_pop              (q_pop),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .bk_status          (bk_status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_payload_byte   (out_payload_byte),
    .out_last           (out_last),
    .out_payload_length (out_payload_length)
  );

  `SFRD_ASSERT_IMPL(a_push_room, q_push, !q_full, "job pushed into a full queue")
  `SFRD_ASSERT_IMPL(a_no_write_in_run, wr_en, !bk_status.run_active,
                    "frame memory written during a payload run")
  `SFRD_ASSERT_NEXT(a_run_ends, bk_status.run_done, !bk_status.run_active,
                    "payload run still active after its last beat")
  `SFRD_ASSERT_IMPL(a_status_single, out_valid && (out_event_res != EV_PAYLOAD),
                    out_last && (out_payload_length == 6'd0),
                    "status result without last mark or with a length")
  `SFRD_ASSERT_IMPL(a_payload_len, out_valid && (out_event_res == EV_PAYLOAD),
                    out_payload_length != 6'd0, "payload beat with zero length")

endmodule
